// ----- design/psa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Packet slot allocator package
// Shared field widths, action and status codes, and register map constants.
// ----------------------------------------------------------------------------
package psa_pkg;

  // Payload field widths.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STATUS_W = 2;

  // Configuration port widths.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Register map: byte address of each register.
  localparam logic [APB_AW-1:0] ADDR_CONSUMER_EN = 3'd0;

  // Requested operation of one input transaction.
  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  // Outcome reported with each result transaction.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_e;

endpackage : psa_pkg
`default_nettype wire

// ----- design/psa_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Packet slot allocator channel interfaces
// Valid/ready channels for action transactions and result transactions.
// ----------------------------------------------------------------------------

// Action channel: one request to the allocator.
interface psa_in_if import psa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [HANDLE_W-1:0] packet_handle;
  logic [SLOT_W-1:0]   release_slot;

  modport source (output valid, action, packet_handle, release_slot, input ready);
  modport sink   (input valid, action, packet_handle, release_slot, output ready);
endinterface : psa_in_if

// Result channel: one answer per action.
interface psa_out_if import psa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic [HANDLE_W-1:0] handle_out;

  modport source (output valid, status, slot_out, handle_out, input ready);
  modport sink   (input valid, status, slot_out, handle_out, output ready);
endinterface : psa_out_if
`default_nettype wire

// ----- design/psa_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Packet slot allocator configuration registers
// APB-style register file holding the consumer enable bit.
// ----------------------------------------------------------------------------
module psa_cfg_regs import psa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic                   consumer_en_o
);

  logic consumer_en_q;
  logic consumer_en_d;
  logic wr_en;

  // The port never inserts wait states.
  assign pready = 1'b1;

  // A write completes in the access phase.
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    consumer_en_d = consumer_en_q;
    if (wr_en && (paddr == ADDR_CONSUMER_EN)) begin
      consumer_en_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      consumer_en_q <= 1'b0;
    end else begin
      consumer_en_q <= consumer_en_d;
    end
  end

  // Read data for the addressed register; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_CONSUMER_EN) begin
      prdata = {{(APB_DW-1){1'b0}}, consumer_en_q};
    end
  end

  assign consumer_en_o = consumer_en_q;

endmodule : psa_cfg_regs
`default_nettype wire

// ----- design/packet_slot_allocator_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Packet slot allocator with free-slot stack and in-order queue
// Hands out slot IDs from a LIFO free stack, stores packet handles per slot
// and returns slots in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one action per transaction: enqueue a packet handle,
//   dequeue the oldest slot, or release a slot ID back to the free stack.
//   out_if returns exactly one result transaction per action, in order.
//   The APB port holds the consumer enable bit; enqueues are refused while
//   it is clear.
// Sequencing:
//   One action is processed at a time. Results of enqueue, release, refused
//   and empty actions are registered from S_EXEC; a dequeue also passes
//   S_HREAD, since the slot ID read from the queue memory addresses the
//   handle memory in a second dependent read. A new action is accepted
//   only in S_IDLE, once the previous result has entered the result register.
// Reset:
//   All slots are free at once, with the highest ID handed out first; no
//   clearing pass runs. A low-water mark on the stack depth tells which
//   stack entries were never written and so stand for their own index.
// Stall:
//   The result register holds its transaction while out_if.ready is low;
//   the next action is still accepted and waits for the register to free.
// ----------------------------------------------------------------------------
module packet_slot_allocator_fifo import psa_pkg::*; #(
  parameter int unsigned SLOTS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  psa_in_if.sink                 in_if,
  psa_out_if.source              out_if,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);
  localparam logic [IW-1:0] LAST_POS = IW'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_HREAD
  } state_e;

  // Control state.
  state_e        state_q, state_d;
  logic [CW-1:0] free_cnt_q, free_cnt_d;
  logic [CW-1:0] mark_q, mark_d;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [CW-1:0] fifo_cnt_q, fifo_cnt_d;
  logic          out_valid_q, out_valid_d;

  // Captured transaction and result payload.
  logic [ACTION_W-1:0] action_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [SLOT_W-1:0]   rel_q;
  logic [IW-1:0]       id_q, id_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [HANDLE_W-1:0] hout_q, hout_d;

  // Memories and their registered read data.
  logic [IW-1:0]       stack_mem [SLOTS];
  logic [IW-1:0]       fifo_mem [SLOTS];
  logic [HANDLE_W-1:0] handle_mem [SLOTS];
  logic [IW-1:0]       stack_rd_q;
  logic [IW-1:0]       fifo_rd_q;
  logic [HANDLE_W-1:0] handle_rd_q;

  // Memory access controls.
  logic          in_acc;
  logic          out_free;
  logic          consumer_en;
  logic [IW-1:0] stack_raddr;
  logic          stack_we;
  logic [IW-1:0] stack_waddr;
  logic [IW-1:0] stack_wdata;
  logic          fifo_we;
  logic          handle_we;
  logic          handle_re;
  logic [IW-1:0] pop_pos;
  logic [IW-1:0] pop_id;
  logic          enq_ok;
  logic          rel_ok;

  // Configuration registers.
  psa_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .consumer_en_o (consumer_en)
  );

  // Handshakes.
  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_q || out_if.ready;

  // Stack top position, and the ID it holds: entries below the low-water
  // mark were never written and stand for their own index.
  assign stack_raddr = IW'(free_cnt_q - CW'(1));
  assign pop_pos     = stack_raddr;
  assign pop_id      = ({1'b0, free_cnt_q} <= {1'b0, mark_q}) ? pop_pos : stack_rd_q;

  assign enq_ok = consumer_en && (free_cnt_q != '0) && (fifo_cnt_q != FULL_CNT);
  assign rel_ok = (free_cnt_q != FULL_CNT) && (32'(rel_q) < 32'(SLOTS));

  assign stack_waddr = IW'(free_cnt_q);
  assign stack_wdata = IW'(rel_q);

  // Next-state and result logic.
  always_comb begin
    state_d     = state_q;
    free_cnt_d  = free_cnt_q;
    mark_d      = mark_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fifo_cnt_d  = fifo_cnt_q;
    out_valid_d = out_valid_q && !out_if.ready;
    id_d        = id_q;
    status_d    = status_q;
    slot_d      = slot_q;
    hout_d      = hout_q;
    stack_we    = 1'b0;
    fifo_we     = 1'b0;
    handle_we   = 1'b0;
    handle_re   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          status_d    = ST_DONE;
          slot_d      = '0;
          hout_d      = '0;
          case (action_q)
            ACT_ENQUEUE: begin
              if (enq_ok) begin
                handle_we  = 1'b1;
                fifo_we    = 1'b1;
                free_cnt_d = free_cnt_q - CW'(1);
                if (free_cnt_d < mark_q) begin
                  mark_d = free_cnt_d;
                end
                tail_d     = (tail_q == LAST_POS) ? '0 : tail_q + IW'(1);
                fifo_cnt_d = fifo_cnt_q + CW'(1);
                slot_d     = SLOT_W'(pop_id);
              end else begin
                status_d = ST_REFUSED;
              end
            end
            ACT_DEQUEUE: begin
              if (fifo_cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                // Second read: the handle of the slot at the queue head.
                handle_re   = 1'b1;
                id_d        = fifo_rd_q;
                head_d      = (head_q == LAST_POS) ? '0 : head_q + IW'(1);
                fifo_cnt_d  = fifo_cnt_q - CW'(1);
                state_d     = S_HREAD;
                out_valid_d = out_valid_q && !out_if.ready;
              end
            end
            ACT_RELEASE: begin
              if (rel_ok) begin
                stack_we   = 1'b1;
                free_cnt_d = free_cnt_q + CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_HREAD: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          status_d    = ST_DONE;
          slot_d      = SLOT_W'(id_q);
          hout_d      = handle_rd_q;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_cnt_q  <= FULL_CNT;
      mark_q      <= FULL_CNT;
      head_q      <= '0;
      tail_q      <= '0;
      fifo_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_cnt_q  <= free_cnt_d;
      mark_q      <= mark_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fifo_cnt_q  <= fifo_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= in_if.action;
      handle_q <= in_if.packet_handle;
      rel_q    <= in_if.release_slot;
    end
    id_q     <= id_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    hout_q   <= hout_d;
  end

  // Free stack memory.
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    if (in_acc) begin
      stack_rd_q <= stack_mem[stack_raddr];
    end
  end

  // Order queue memory.
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[tail_q] <= pop_id;
    end
    if (in_acc) begin
      fifo_rd_q <= fifo_mem[head_q];
    end
  end

  // Packet handle memory.
  always_ff @(posedge clk_i) begin
    if (handle_we) begin
      handle_mem[pop_id] <= handle_q;
    end
    if (handle_re) begin
      handle_rd_q <= handle_mem[fifo_rd_q];
    end
  end

  // Result channel.
  assign out_if.valid      = out_valid_q;
  assign out_if.status     = status_q;
  assign out_if.slot_out   = slot_q;
  assign out_if.handle_out = hout_q;

`ifndef SYNTHESIS
  a_free_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= FULL_CNT)
    else $error("Free stack depth exceeds the slot count.");

  a_fifo_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= FULL_CNT)
    else $error("Queue occupancy exceeds the slot count.");

  a_mark_below_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q <= free_cnt_q)
    else $error("Stack low-water mark lies above the stack depth.");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_cnt_q == '0) |-> (head_q == tail_q))
    else $error("Empty queue with head and tail apart.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ((state_q == S_EXEC) && !in_if.ready))
    else $error("Accepted action did not start execution alone.");
`endif

endmodule : packet_slot_allocator_fifo
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet slot allocator testbench
// Drives enqueue, dequeue and release transactions through the action channel,
// toggles the consumer enable register over the APB port between phases, and
// compares every result transaction with a cycle-free prediction of the free
// stack, the order ring and the per-slot handle store.
// ----------------------------------------------------------------------------
module testbench;
  import psa_pkg::*;

  localparam int unsigned SLOTS         = 64;
  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned WATCHDOG_NS   = 4_000_000;

  // Action code 3 is not decoded by the block; it must answer with a plain done.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // Character of the random traffic over a stretch of items.
  typedef enum int unsigned {
    MODE_FILL,
    MODE_DRAIN,
    MODE_STEADY,
    MODE_NOISE
  } feed_mode_e;

  // Receiver behavior over a stretch of cycles.
  typedef enum int unsigned {
    SINK_OPEN,
    SINK_CHOPPY,
    SINK_STALLS
  } sink_mode_e;

  // One predicted result transaction.
  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
  } reply_t;

  // Tracks the allocator state and the results still owed by the block.
  class slot_ledger;
    bit                  consumer_en;
    logic [SLOT_W-1:0]   free_ids   [SLOTS];
    int unsigned         free_cnt;
    logic [SLOT_W-1:0]   order_ring [SLOTS];
    int unsigned         ring_head;
    int unsigned         ring_tail;
    int unsigned         ring_fill;
    logic [HANDLE_W-1:0] handles    [SLOTS];
    reply_t              owed_replies[$];
    int unsigned         mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        free_ids[i]   = SLOT_W'(i);
        order_ring[i] = '0;
        handles[i]    = '0;
      end
      consumer_en = 1'b0;
      free_cnt    = SLOTS;
      ring_head   = 0;
      ring_tail   = 0;
      ring_fill   = 0;
      mismatches  = 0;
    endfunction

    function void set_consumer(bit en);
      consumer_en = en;
    endfunction

    function int unsigned pending();
      return owed_replies.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Applies one accepted action to the state and queues the result it owes.
    function reply_t note_action(logic [ACTION_W-1:0] act, logic [HANDLE_W-1:0] hnd,
                                 logic [SLOT_W-1:0] rel);
      reply_t            r;
      logic [SLOT_W-1:0] id;
      r.status = ST_DONE;
      r.slot   = '0;
      r.handle = '0;
      case (act)
        ACT_ENQUEUE: begin
          if (!consumer_en || free_cnt == 0 || ring_fill >= SLOTS) begin
            r.status = ST_REFUSED;
          end else begin
            free_cnt--;
            id                    = free_ids[free_cnt];
            handles[id]           = hnd;
            order_ring[ring_tail] = id;
            ring_tail             = (ring_tail + 1) % SLOTS;
            ring_fill++;
            r.slot = id;
          end
        end
        ACT_DEQUEUE: begin
          if (ring_fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            id        = order_ring[ring_head];
            ring_head = (ring_head + 1) % SLOTS;
            ring_fill--;
            r.slot   = id;
            r.handle = handles[id];
          end
        end
        ACT_RELEASE: begin
          // A push onto a full stack is dropped; duplicates are accepted.
          if (free_cnt < SLOTS) begin
            free_ids[free_cnt] = rel;
            free_cnt++;
          end
        end
        default: ;
      endcase
      owed_replies.push_back(r);
      return r;
    endfunction

    // Compares one result transaction with the oldest owed result.
    task check_result(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl,
                      logic [HANDLE_W-1:0] hd);
      reply_t want;
      if (owed_replies.size() == 0) begin
        report($sformatf("unexpected result: status %0d slot %0d handle %h", st, sl, hd));
        return;
      end
      want = owed_replies.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, expected %s", st, want.status.name()));
      if (sl !== want.slot)
        report($sformatf("slot %0d, expected %0d", sl, want.slot));
      if (hd !== want.handle)
        report($sformatf("handle %h, expected %h", hd, want.handle));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  psa_in_if  act_ch ();
  psa_out_if res_ch ();

  slot_ledger          ledger = new();
  logic [SLOT_W-1:0]   held_ids[$];
  sink_mode_e          sink_mode  = SINK_OPEN;
  int unsigned         sink_left  = 0;
  int unsigned         stall_left = 0;

  packet_slot_allocator_fifo #(
    .SLOTS (SLOTS)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (act_ch),
    .out_if  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Result side: check each transaction, then pick the next ready value.
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
      ledger.check_result(res_ch.status, res_ch.slot_out, res_ch.handle_out);

    if (sink_left == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(0, 2));
      sink_left <= $urandom_range(20, 200);
    end else begin
      sink_left <= sink_left - 1;
    end

    case (sink_mode)
      SINK_OPEN: res_ch.ready <= 1'b1;
      SINK_CHOPPY: res_ch.ready <= ($urandom_range(0, 9) < 6);
      default: begin
        if (stall_left != 0) begin
          res_ch.ready <= 1'b0;
          stall_left   <= stall_left - 1;
        end else begin
          res_ch.ready <= 1'b1;
          if ($urandom_range(0, 7) == 0)
            stall_left <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  // APB write with setup and access phases; the ledger follows once the access phase completes.
  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_CONSUMER_EN)
      ledger.set_consumer(data[0]);
  endtask

  // Presents one action and returns at the edge where it is accepted.
  task automatic send_action(logic [ACTION_W-1:0] act, logic [HANDLE_W-1:0] hnd,
                             logic [SLOT_W-1:0] rel);
    reply_t r;
    act_ch.valid         <= 1'b1;
    act_ch.action        <= act;
    act_ch.packet_handle <= hnd;
    act_ch.release_slot  <= rel;
    do @(posedge clk_i); while (act_ch.ready !== 1'b1);
    r = ledger.note_action(act, hnd, rel);
    // Dequeued slots become candidates for a later release.
    if (act == ACT_DEQUEUE && r.status == ST_DONE)
      held_ids.push_back(r.slot);
  endtask

  // Stops the action stream and waits until every owed result has arrived or DRAIN_LIMIT runs out.
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    act_ch.valid <= 1'b0;
    while (ledger.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [HANDLE_W-1:0] pick_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Chooses one action according to the traffic mode and sends it.
  task automatic issue_random_item(feed_mode_e mode, output bit counted);
    logic [ACTION_W-1:0] act;
    logic [SLOT_W-1:0]   rel;
    int unsigned         roll;
    int unsigned         idx;
    roll = $urandom_range(0, 99);
    rel  = SLOT_W'($urandom);
    case (mode)
      MODE_FILL:
        act = (roll < 80) ? ACT_ENQUEUE : (roll < 90) ? ACT_DEQUEUE : ACT_RELEASE;
      MODE_DRAIN:
        act = (roll < 50) ? ACT_DEQUEUE : (roll < 90) ? ACT_RELEASE : ACT_ENQUEUE;
      MODE_STEADY:
        act = (roll < 32) ? ACT_ENQUEUE : (roll < 64) ? ACT_DEQUEUE :
              (roll < 92) ? ACT_RELEASE : ACTION_W'($urandom_range(0, 3));
      default:
        act = ACTION_W'($urandom_range(0, 3));
    endcase
    // Well-formed releases return a slot that was dequeued; a few repeat it.
    if (act == ACT_RELEASE && held_ids.size() != 0 && $urandom_range(0, 9) != 0) begin
      idx = $urandom_range(0, held_ids.size() - 1);
      rel = held_ids[idx];
      if ($urandom_range(0, 9) != 0)
        held_ids.delete(idx);
    end
    send_action(act, pick_handle(), rel);
    counted = (act != ACT_UNUSED);
  endtask

  // Random traffic in bursts with gaps; the mode changes every few dozen items.
  task automatic run_random(int unsigned count);
    int unsigned issued;
    int unsigned burst;
    int unsigned gap;
    int unsigned mode_left;
    feed_mode_e  mode;
    bit          counted;
    issued    = 0;
    mode_left = 0;
    mode      = MODE_STEADY;
    while (issued < count) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst; i++) begin
        if (mode_left == 0) begin
          mode      = feed_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        issue_random_item(mode, counted);
        if (counted)
          issued++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        act_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    act_ch.valid <= 1'b0;
  endtask

  // Main sequence.
  initial begin
    rst_ni               <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    act_ch.valid         <= 1'b0;
    act_ch.action        <= ACT_ENQUEUE;
    act_ch.packet_handle <= '0;
    act_ch.release_slot  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Consumer disabled after reset: refused enqueue, empty dequeue,
    // release onto a full stack, and the undecoded action code.
    send_action(ACT_ENQUEUE, 32'h1234_5678, 6'd0);
    send_action(ACT_DEQUEUE, 32'h0000_0000, 6'd0);
    send_action(ACT_RELEASE, 32'h0000_0000, 6'd0);
    send_action(ACT_UNUSED,  32'hFFFF_FFFF, 6'd63);
    wait_drained();

    apb_write(ADDR_CONSUMER_EN, 32'h0000_0001);

    // Highest IDs first, handle extremes, in-order dequeue, duplicate
    // release, release dropped on a full stack, reuse of released slots.
    send_action(ACT_ENQUEUE, 32'h0000_0000, 6'd0);
    send_action(ACT_ENQUEUE, 32'hFFFF_FFFF, 6'd0);
    send_action(ACT_ENQUEUE, 32'hA5A5_A5A5, 6'd63);
    send_action(ACT_DEQUEUE, 32'h0000_0000, 6'd0);
    send_action(ACT_DEQUEUE, 32'h0000_0000, 6'd0);
    send_action(ACT_RELEASE, 32'h0000_0000, 6'd63);
    send_action(ACT_RELEASE, 32'h0000_0000, 6'd62);
    send_action(ACT_RELEASE, 32'h0000_0000, 6'd63);
    send_action(ACT_RELEASE, 32'hFFFF_FFFF, 6'd5);
    send_action(ACT_ENQUEUE, 32'h0000_0001, 6'd0);
    send_action(ACT_ENQUEUE, 32'h8000_0000, 6'd0);
    send_action(ACT_DEQUEUE, 32'h0000_0000, 6'd0);
    send_action(ACT_DEQUEUE, 32'h0000_0000, 6'd0);
    send_action(ACT_DEQUEUE, 32'h0000_0000, 6'd0);
    send_action(ACT_DEQUEUE, 32'h0000_0000, 6'd0);
    send_action(ACT_UNUSED,  32'h0000_0000, 6'd0);
    send_action(ACT_RELEASE, 32'h0000_0000, 6'd0);
    held_ids.delete();
    wait_drained();

    run_random(700);
    wait_drained();
    apb_write(ADDR_CONSUMER_EN, 32'hFFFF_FFFE);
    run_random(150);
    wait_drained();
    apb_write(ADDR_CONSUMER_EN, 32'hFFFF_FFFF);
    run_random(750);
    wait_drained();

    if (ledger.pending() != 0)
      ledger.report($sformatf("%0d results never arrived", ledger.pending()));

    if (ledger.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(WATCHDOG_NS);
    $display("simulation failed");
    $finish;
  end

endmodule : testbench
